### hw/rtl/sur_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_pkg
// Types, constants and helper functions shared by the scanline reorder unit.
// ----------------------------------------------------------------------------
package sur_pkg;

   // Widths of the register and item fields.
   localparam int unsigned FORMAT_W   = 4;
   localparam int unsigned ROW_W      = 15;
   localparam int unsigned OFFSET_W   = 14;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned LANES      = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 15;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_FORMAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES  = 2'd2;

   // Format codes: unit size, then bit order, then byte order.
   localparam logic [FORMAT_W-1:0] FMT_8_MM  = 4'd0;
   localparam logic [FORMAT_W-1:0] FMT_16_MM = 4'd1;
   localparam logic [FORMAT_W-1:0] FMT_32_MM = 4'd2;
   localparam logic [FORMAT_W-1:0] FMT_8_LM  = 4'd3;
   localparam logic [FORMAT_W-1:0] FMT_16_LM = 4'd4;
   localparam logic [FORMAT_W-1:0] FMT_32_LM = 4'd5;
   localparam logic [FORMAT_W-1:0] FMT_8_ML  = 4'd6;
   localparam logic [FORMAT_W-1:0] FMT_16_ML = 4'd7;
   localparam logic [FORMAT_W-1:0] FMT_32_ML = 4'd8;
   localparam logic [FORMAT_W-1:0] FMT_8_LL  = 4'd9;
   localparam logic [FORMAT_W-1:0] FMT_16_LL = 4'd10;
   localparam logic [FORMAT_W-1:0] FMT_32_LL = 4'd11;

   // Largest format code in use and the row length limit.
   localparam logic [FORMAT_W-1:0] FORMAT_MAX  = 4'd11;
   localparam logic [ROW_W-1:0]    ROW_LIMIT   = 15'd16384;
   localparam logic [ROW_W-1:0]    ROW_BYTES_RESET = 15'd1;

   // Conversion kinds: the low two bits pick the byte order, bit 2 adds
   // a bit reversal inside every byte.
   localparam logic [1:0] UNIT_COPY   = 2'd0;
   localparam logic [1:0] UNIT_SWAP2  = 2'd1;
   localparam logic [1:0] UNIT_SWAP4  = 2'd2;
   localparam logic [1:0] UNIT_HALVES = 2'd3;
   localparam logic [2:0] KIND_COPY   = 3'd0;

   // Conversion kind for each source (outer) and destination (inner) format.
   localparam logic [2:0] CONV_KIND [12][12] = '{
      '{3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4},
      '{3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4},
      '{3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4},
      '{3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0},
      '{3'd5, 3'd5, 3'd5, 3'd1, 3'd0, 3'd3, 3'd5, 3'd4, 3'd7, 3'd1, 3'd1, 3'd1},
      '{3'd6, 3'd6, 3'd6, 3'd2, 3'd3, 3'd0, 3'd6, 3'd7, 3'd4, 3'd2, 3'd2, 3'd2},
      '{3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4},
      '{3'd1, 3'd1, 3'd1, 3'd5, 3'd4, 3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd5, 3'd5},
      '{3'd2, 3'd2, 3'd2, 3'd6, 3'd7, 3'd4, 3'd2, 3'd3, 3'd0, 3'd6, 3'd6, 3'd6},
      '{3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0},
      '{3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0},
      '{3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0}
   };

   // Decoded conversion, passed from the decoder to the datapath.
   typedef struct packed {
      logic [2:0] kind;
      logic       half_msb;
   } conv_type;

   // Lane j of a partial 32-bit unit holding r valid bytes (1 to 3).
   function automatic logic partial4(input logic [1:0] j, input logic [1:0] r,
                                     input logic msb, input logic halves);
      logic hit;
      if (!halves) begin
         if (msb) begin
            hit = (j == 2'd0) || (j == 2'd1 && r >= 2'd2) || (j == 2'd2 && r == 2'd3);
         end else begin
            hit = (j == 2'd3) || (j == 2'd2 && r >= 2'd2) || (j == 2'd1 && r == 2'd3);
         end
      end else if (msb) begin
         hit = (j == 2'd1) || (j == 2'd0 && r >= 2'd2) || (j == 2'd3 && r == 2'd3);
      end else begin
         hit = (j == 2'd2) || (j == 2'd3 && r >= 2'd2) || (j == 2'd0 && r == 2'd3);
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sur_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_req_if
// Input channel: one group of four source bytes per item.
// ----------------------------------------------------------------------------
interface sur_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] unit_data;
   logic        last_row;

   modport source (output valid, output unit_data, output last_row, input ready);
   modport sink   (input valid, input unit_data, input last_row, output ready);
endinterface
`default_nettype wire

### hw/rtl/sur_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_rsp_if
// Result channel: four converted bytes with their write mask per item.
// ----------------------------------------------------------------------------
interface sur_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_data;
   logic [3:0]  byte_mask;
   logic        end_of_row;

   modport source (output valid, output out_data, output byte_mask,
                   output end_of_row, input ready);
   modport sink   (input valid, input out_data, input byte_mask,
                   input end_of_row, output ready);
endinterface
`default_nettype wire

### hw/rtl/scanline_unit_reorder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_unit_reorder_unit
// Converts bitmap scanline groups between unit size, bit order and byte
// order formats.
// ----------------------------------------------------------------------------
// The unit takes one group of four row bytes per clock and returns its
// converted group in the next cycle from a result register, so the sustained
// rate is one item per cycle. The only limit on rate is the result register:
// a new item is taken whenever that register is empty or its item is taken
// in the same cycle. The row offset counter advances with every accepted
// item; configuration writes should be made only between rows while no item
// is in flight.
module scanline_unit_reorder_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [sur_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sur_pkg::CSR_DATA_W-1:0] csr_write_data,
   sur_req_if.sink                             req_if,
   sur_rsp_if.source                           rsp_if
);
   import sur_pkg::*;

   logic [FORMAT_W-1:0] src_format_ff;
   logic [FORMAT_W-1:0] dst_format_ff;
   logic [ROW_W-1:0]    row_bytes_ff;
   logic [OFFSET_W-1:0] row_offset_ff;
   logic [OFFSET_W-1:0] row_offset_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   out_data_ff;
   logic [LANES-1:0]    byte_mask_ff;
   logic                end_of_row_ff;

   conv_type            conv;
   logic [DATA_W-1:0]   word;
   logic [DATA_W-1:0]   lane_bits;
   logic [LANES-1:0]    mask;
   logic                row_end;
   logic                accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_format_ff <= '0;
         dst_format_ff <= '0;
         row_bytes_ff  <= ROW_BYTES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SRC_FORMAT: src_format_ff <= csr_write_data[FORMAT_W-1:0];
            CSR_DST_FORMAT: dst_format_ff <= csr_write_data[FORMAT_W-1:0];
            CSR_ROW_BYTES:  row_bytes_ff  <= csr_write_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   sur_decode u_decode (
      .src_format (src_format_ff),
      .dst_format (dst_format_ff),
      .conv       (conv)
   );

   sur_swizzle u_swizzle (
      .unit_data (req_if.unit_data),
      .kind      (conv.kind),
      .word      (word)
   );

   sur_lanes u_lanes (
      .row_offset  (row_offset_ff),
      .row_bytes   (row_bytes_ff),
      .last_row    (req_if.last_row),
      .conv        (conv),
      .byte_mask   (mask),
      .end_of_row  (row_end),
      .next_offset (row_offset_in)
   );

   // Handshake: take an item whenever the result register frees up.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   // Unwritten lanes read as zero.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_bits[8*i +: 8] = {8{mask[i]}};
      end
   end

   // Row offset counter and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_offset_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            row_offset_ff <= row_offset_in;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff   <= word & lane_bits;
         byte_mask_ff  <= mask;
         end_of_row_ff <= row_end;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_data   = out_data_ff;
   assign rsp_if.byte_mask  = byte_mask_ff;
   assign rsp_if.end_of_row = end_of_row_ff;

endmodule
`default_nettype wire

### hw/rtl/sur_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_decode
// Maps the source and destination format codes to a conversion kind and
// the half order used for a partial last unit.
// ----------------------------------------------------------------------------
module sur_decode (
   input  wire logic [sur_pkg::FORMAT_W-1:0] src_format,
   input  wire logic [sur_pkg::FORMAT_W-1:0] dst_format,
   output sur_pkg::conv_type                 conv
);
   import sur_pkg::*;

   logic formats_ok;

   // Unused codes fall back to a plain copy with LSB-first half order.
   assign formats_ok = (src_format <= FORMAT_MAX) && (dst_format <= FORMAT_MAX);

   always_comb begin
      conv.kind     = KIND_COPY;
      conv.half_msb = 1'b0;
      if (formats_ok) begin
         conv.kind = CONV_KIND[src_format][dst_format];
         // MSB-first halves for 16/32-bit LM and ML sources, unless the
         // destination is a 32-bit LM or ML unit.
         if (src_format == FMT_16_LM || src_format == FMT_32_LM ||
             src_format == FMT_16_ML || src_format == FMT_32_ML) begin
            conv.half_msb = !(dst_format == FMT_32_LM || dst_format == FMT_32_ML);
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sur_swizzle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_swizzle
// Reorders the four bytes of a group and optionally reverses the bits of
// every byte.
// ----------------------------------------------------------------------------
module sur_swizzle (
   input  wire logic [sur_pkg::DATA_W-1:0] unit_data,
   input  wire logic [2:0]                 kind,
   output logic      [sur_pkg::DATA_W-1:0] word
);
   import sur_pkg::*;

   logic [7:0] src_byte [LANES];
   logic [7:0] ord_byte [LANES];

   // Split the group into bytes.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         src_byte[i] = unit_data[8*i +: 8];
      end
   end

   // Byte order.
   always_comb begin
      case (kind[1:0])
         UNIT_SWAP2: begin
            ord_byte[0] = src_byte[1];
            ord_byte[1] = src_byte[0];
            ord_byte[2] = src_byte[3];
            ord_byte[3] = src_byte[2];
         end
         UNIT_SWAP4: begin
            ord_byte[0] = src_byte[3];
            ord_byte[1] = src_byte[2];
            ord_byte[2] = src_byte[1];
            ord_byte[3] = src_byte[0];
         end
         UNIT_HALVES: begin
            ord_byte[0] = src_byte[2];
            ord_byte[1] = src_byte[3];
            ord_byte[2] = src_byte[0];
            ord_byte[3] = src_byte[1];
         end
         default: begin
            ord_byte = src_byte;
         end
      endcase
   end

   // Bit reversal within each byte.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int k = 0; k < 8; k++) begin
            word[8*i + k] = kind[2] ? ord_byte[i][7-k] : ord_byte[i][k];
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sur_lanes.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_lanes
// Works out which destination byte lanes of a group are written, whether
// the group ends its row and the row offset of the next group.
// ----------------------------------------------------------------------------
module sur_lanes (
   input  wire logic [sur_pkg::OFFSET_W-1:0] row_offset,
   input  wire logic [sur_pkg::ROW_W-1:0]    row_bytes,
   input  wire logic                         last_row,
   input  wire sur_pkg::conv_type            conv,
   output logic      [sur_pkg::LANES-1:0]    byte_mask,
   output logic                              end_of_row,
   output logic      [sur_pkg::OFFSET_W-1:0] next_offset
);
   import sur_pkg::*;

   logic [ROW_W-1:0] rb;
   logic [15:0]      rb_w;
   logic [15:0]      off_w;
   logic [15:0]      round2;
   logic [15:0]      round4;
   logic [15:0]      base;
   logic [15:0]      off_plus4;
   logic [1:0]       rem;

   // Row length, capped at the largest row.
   assign rb        = (row_bytes > ROW_LIMIT) ? ROW_LIMIT : row_bytes;
   assign rb_w      = {1'b0, rb};
   assign off_w     = {2'b00, row_offset};
   assign rem       = rb[1:0];
   assign base      = {rb_w[15:2], 2'b00};
   assign round2    = (rb_w + 16'd1) & 16'hFFFE;
   assign round4    = (rb_w + 16'd3) & 16'hFFFC;
   assign off_plus4 = off_w + 16'd4;

   // Per-lane write decision; lanes are independent of each other.
   always_comb begin
      logic [15:0] p;
      logic [15:0] rel;
      byte_mask = '0;
      for (int i = 0; i < LANES; i++) begin
         p   = off_w + 16'(i);
         rel = p - base;
         case (conv.kind[1:0])
            UNIT_COPY: begin
               byte_mask[i] = p < rb_w;
            end
            UNIT_SWAP2: begin
               if (last_row && rb[0]) begin
                  if (p < rb_w - 16'd1) begin
                     byte_mask[i] = 1'b1;
                  end else if (p == rb_w - 16'd1) begin
                     byte_mask[i] = conv.half_msb;
                  end else if (p == rb_w) begin
                     byte_mask[i] = !conv.half_msb;
                  end
               end else begin
                  byte_mask[i] = p < round2;
               end
            end
            default: begin
               if (last_row && rem != 2'd0) begin
                  if (p < base) begin
                     byte_mask[i] = 1'b1;
                  end else if (p < base + 16'd4) begin
                     byte_mask[i] = partial4(rel[1:0], rem, conv.half_msb,
                                             conv.kind[1:0] == UNIT_HALVES);
                  end
               end else begin
                  byte_mask[i] = p < round4;
               end
            end
         endcase
      end
   end

   // Row end and offset of the following group.
   assign end_of_row  = off_plus4 >= rb_w;
   assign next_offset = end_of_row ? '0 : off_plus4[OFFSET_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/sur_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sur_checker
// Port-level checks of the scanline reorder unit, bound to its top level.
// ----------------------------------------------------------------------------
module sur_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] out_data,
   input wire logic [3:0]  byte_mask,
   input wire logic        end_of_row
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_data) &&
      $stable(byte_mask) && $stable(end_of_row))
      else $error("stalled result changed");

   // Every accepted item shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without an accepted item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without an item");

   // Lanes that are not written carry zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (byte_mask[0] || out_data[7:0] == 8'h00) &&
                    (byte_mask[1] || out_data[15:8] == 8'h00) &&
                    (byte_mask[2] || out_data[23:16] == 8'h00) &&
                    (byte_mask[3] || out_data[31:24] == 8'h00))
      else $error("unwritten lane is not zero");

endmodule

bind scanline_unit_reorder_unit sur_checker u_sur_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .out_data   (rsp_if.out_data),
   .byte_mask  (rsp_if.byte_mask),
   .end_of_row (rsp_if.end_of_row)
);
`default_nettype wire
